[src/assert_macros.svh]
// Assertion macros for the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition implies a consequence in the same cycle.
`define ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Condition implies a consequence in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[src/pptraj_pkg.sv]
// Shared types, constants and field offsets of the trajectory evaluator.
`default_nettype none
package pptraj_pkg;
   localparam int MAX_SEGMENTS_DEF = 8;
   localparam int POLY_TERMS_DEF   = 8;
   localparam int AXES             = 3;
   localparam int NUM_POLY         = 6;
   localparam int COEF_W           = 64;
   localparam int TIME_W           = 48;
   localparam int POS_W            = 32;
   localparam int E_W              = 50;
   localparam int MAG_W            = 64;
   localparam int PROD_W           = 128;
   localparam int CHUNK_W          = 16;
   localparam int MUL_STEPS        = MAG_W / CHUNK_W;
   localparam int FRAC_SH          = 16;
   localparam int BADDR_MAX_W      = 7;
   localparam int K_MAX_W          = 4;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_IDX_W-1:0] CSR_SEGS   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ZHOLD  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT = 2'd2;

   localparam int REQ_DATA_W = 224;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 200;

   localparam int F_AXIS = 0;
   localparam int F_SEG  = 2;
   localparam int F_CIDX = 5;
   localparam int F_CVAL = 8;
   localparam int F_BIDX = 72;
   localparam int F_TIME = 76;
   localparam int F_MX   = 124;
   localparam int F_MY   = 156;

   typedef enum logic [1:0] {
      FUNC_COEF  = 2'd0,
      FUNC_BOUND = 2'd1,
      FUNC_ODOM  = 2'd2,
      FUNC_NONE  = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      B_NONE  = 3'd0,
      B_LAST  = 3'd1,
      B_PREV  = 3'd2,
      B_FIRST = 3'd3,
      B_SCAN  = 3'd4
   } bop_type;

   typedef struct packed {
      logic                   take_start;
      logic                   take_odo;
      logic                   b_rd;
      logic [BADDR_MAX_W-1:0] b_addr;
      bop_type                bop;
      logic                   sel_seg;
      logic                   c_rd;
      logic [1:0]             axis;
      logic [K_MAX_W-1:0]     k;
      logic                   is_vel;
      logic                   first;
      logic                   c_lat;
      logic                   mul_step;
      logic                   mul_fin;
      logic                   add;
      logic                   store;
      logic [2:0]             p;
      logic                   publish;
   } dp_cmd_type;

   typedef struct packed {
      logic [BADDR_MAX_W-1:0] n_eff;
      logic                   started;
      logic                   rsp_free;
   } dp_status_type;
endpackage
`default_nettype wire

[src/pptraj_ram.sv]
// Generic single write port, single read port RAM with registered read.
`default_nettype none
module pptraj_ram #(
   parameter int WIDTH = pptraj_pkg::COEF_W,
   parameter int DEPTH = pptraj_pkg::MAX_SEGMENTS_DEF,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

[src/pptraj_ctrl.sv]
// Sequencer: boundary search, Horner steps and multiplier iterations.
`default_nettype none
module pptraj_ctrl #(
   parameter int MAX_SEGMENTS = pptraj_pkg::MAX_SEGMENTS_DEF,
   parameter int POLY_TERMS   = pptraj_pkg::POLY_TERMS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_accept,
   input  pptraj_pkg::func_type      req_func,
   input  pptraj_pkg::dp_status_type status,
   output logic                      req_ready,
   output pptraj_pkg::dp_cmd_type    cmd
);
   import pptraj_pkg::*;

   localparam int JW  = $clog2(MAX_SEGMENTS + 3);
   localparam int KW  = $clog2(POLY_TERMS);
   localparam int MCW = $clog2(MUL_STEPS);
   localparam logic [2:0] P_LAST = 3'(NUM_POLY - 1);
   localparam logic [2:0] P_VEL  = 3'(AXES);

   typedef enum logic [9:0] {
      S_IDLE  = 10'b0000000001,
      S_BRD   = 10'b0000000010,
      S_BWAIT = 10'b0000000100,
      S_SEL   = 10'b0000001000,
      S_CRD   = 10'b0000010000,
      S_CLAT  = 10'b0000100000,
      S_MRUN  = 10'b0001000000,
      S_MFIN  = 10'b0010000000,
      S_ADD   = 10'b0100000000,
      S_STORE = 10'b1000000000
   } state_type;

   // result hand-off waits in H_DONE
   typedef enum logic {
      H_RUN  = 1'b0,
      H_DONE = 1'b1
   } hold_type;

   state_type        state_ff, state_in;
   hold_type         hold_ff, hold_in;
   logic [JW-1:0]    j_ff, j_in;
   logic [2:0]       p_ff, p_in;
   logic [KW-1:0]    k_ff, k_in;
   logic [MCW-1:0]   mc_ff, mc_in;
   logic             is_vel;
   logic [KW-1:0]    k_last;
   logic [JW-1:0]    j_last;

   assign is_vel = (p_ff >= P_VEL);
   assign k_last = is_vel ? KW'(POLY_TERMS - 2) : KW'(POLY_TERMS - 1);
   assign j_last = JW'(status.n_eff) + JW'(2);

   always_comb begin
      state_in   = state_ff;
      hold_in    = hold_ff;
      j_in       = j_ff;
      p_in       = p_ff;
      k_in       = k_ff;
      mc_in      = mc_ff;
      req_ready  = 1'b0;
      cmd        = '0;
      cmd.axis   = is_vel ? 2'(p_ff - P_VEL) : 2'(p_ff);
      cmd.k      = K_MAX_W'(k_ff);
      cmd.is_vel = is_vel;
      cmd.first  = (k_ff == '0);
      cmd.p      = p_ff;

      if (hold_ff == H_DONE) begin
         if (status.rsp_free) begin
            cmd.publish = 1'b1;
            hold_in     = H_RUN;
            state_in    = S_IDLE;
         end
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               req_ready = 1'b1;
               if (req_accept && req_func == FUNC_ODOM) begin
                  if (status.started) begin
                     cmd.take_odo = 1'b1;
                     j_in         = '0;
                     state_in     = S_BRD;
                  end else begin
                     cmd.take_start = 1'b1;
                  end
               end
            end
            S_BRD: begin
               cmd.b_rd = 1'b1;
               if (j_ff == JW'(0)) begin
                  cmd.b_addr = status.n_eff;
                  cmd.bop    = B_LAST;
               end else if (j_ff == JW'(1)) begin
                  cmd.b_addr = status.n_eff - BADDR_MAX_W'(1);
                  cmd.bop    = B_PREV;
               end else if (j_ff == JW'(2)) begin
                  cmd.b_addr = '0;
                  cmd.bop    = B_FIRST;
               end else begin
                  cmd.b_addr = BADDR_MAX_W'(j_ff - JW'(2));
                  cmd.bop    = B_SCAN;
               end
               if (j_ff == j_last) begin
                  state_in = S_BWAIT;
               end else begin
                  j_in = j_ff + JW'(1);
               end
            end
            S_BWAIT: begin
               state_in = S_SEL;
            end
            S_SEL: begin
               cmd.sel_seg = 1'b1;
               p_in        = '0;
               k_in        = '0;
               state_in    = S_CRD;
            end
            S_CRD: begin
               cmd.c_rd = 1'b1;
               state_in = S_CLAT;
            end
            S_CLAT: begin
               cmd.c_lat = 1'b1;
               if (k_ff == '0) begin
                  if (k_ff == k_last) begin
                     state_in = S_STORE;
                  end else begin
                     k_in     = k_ff + KW'(1);
                     state_in = S_CRD;
                  end
               end else begin
                  mc_in    = '0;
                  state_in = S_MRUN;
               end
            end
            S_MRUN: begin
               cmd.mul_step = 1'b1;
               if (mc_ff == MCW'(MUL_STEPS - 1)) begin
                  state_in = S_MFIN;
               end else begin
                  mc_in = mc_ff + MCW'(1);
               end
            end
            S_MFIN: begin
               cmd.mul_fin = 1'b1;
               state_in    = S_ADD;
            end
            S_ADD: begin
               cmd.add = 1'b1;
               if (k_ff == k_last) begin
                  state_in = S_STORE;
               end else begin
                  k_in     = k_ff + KW'(1);
                  state_in = S_CRD;
               end
            end
            S_STORE: begin
               cmd.store = 1'b1;
               if (p_ff == P_LAST) begin
                  hold_in = H_DONE;
               end else begin
                  p_in     = p_ff + 3'd1;
                  k_in     = '0;
                  state_in = S_CRD;
               end
            end
            default: begin
               state_in = S_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         hold_ff  <= H_RUN;
         j_ff     <= '0;
         p_ff     <= '0;
         k_ff     <= '0;
         mc_ff    <= '0;
      end else begin
         state_ff <= state_in;
         hold_ff  <= hold_in;
         j_ff     <= j_in;
         p_ff     <= p_in;
         k_ff     <= k_in;
         mc_ff    <= mc_in;
      end
   end
endmodule
`default_nettype wire

[src/pptraj_dp.sv]
// Datapath: tables, config registers, segment select, shared multiplier, results.
`default_nettype none
module pptraj_dp #(
   parameter int MAX_SEGMENTS = pptraj_pkg::MAX_SEGMENTS_DEF,
   parameter int POLY_TERMS   = pptraj_pkg::POLY_TERMS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_accept,
   input  pptraj_pkg::func_type              req_func,
   input  logic [pptraj_pkg::REQ_DATA_W-1:0] req_data,
   input  logic                              csr_we,
   input  logic [pptraj_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [pptraj_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  pptraj_pkg::dp_cmd_type            cmd,
   output pptraj_pkg::dp_status_type         status,
   input  logic                              rsp_ready,
   output logic                              rsp_valid,
   output logic [pptraj_pkg::RSP_DATA_W-1:0] rsp_data
);
   import pptraj_pkg::*;

   localparam int CDEPTH = AXES * MAX_SEGMENTS * POLY_TERMS;
   localparam int CAW    = $clog2(CDEPTH);
   localparam int BDEPTH = MAX_SEGMENTS + 1;
   localparam int BAW    = $clog2(BDEPTH);
   localparam int SW     = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
   localparam int VM_W   = COEF_W + K_MAX_W + 1;
   localparam int HI_B   = COEF_W + FRAC_SH - 1;
   localparam logic [COEF_W-1:0] S64_MAX = {1'b0, {(COEF_W-1){1'b1}}};
   localparam logic [COEF_W-1:0] S64_MIN = {1'b1, {(COEF_W-1){1'b0}}};
   localparam logic [POS_W-1:0]  S32_MAX = {1'b0, {(POS_W-1){1'b1}}};
   localparam logic [POS_W-1:0]  S32_MIN = {1'b1, {(POS_W-1){1'b0}}};

   function automatic logic [COEF_W-1:0] sat_add(input logic [COEF_W-1:0] a,
                                                 input logic [COEF_W-1:0] b);
      logic [COEF_W-1:0] s;
      s = a + b;
      if (a[COEF_W-1] == b[COEF_W-1] && s[COEF_W-1] != a[COEF_W-1]) begin
         return a[COEF_W-1] ? S64_MIN : S64_MAX;
      end
      return s;
   endfunction

   function automatic logic [POS_W-1:0] pos_sat(input logic [POS_W-1:0] a,
                                                input logic [POS_W-1:0] b);
      logic [POS_W:0] s;
      s = {a[POS_W-1], a} + {b[POS_W-1], b};
      if (s[POS_W] != s[POS_W-1]) begin
         return s[POS_W] ? S32_MIN : S32_MAX;
      end
      return s[POS_W-1:0];
   endfunction

   // request fields
   logic [1:0]        f_axis;
   logic [2:0]        f_seg;
   logic [2:0]        f_cidx;
   logic [COEF_W-1:0] f_cval;
   logic [3:0]        f_bidx;
   logic [TIME_W-1:0] f_time;
   logic [POS_W-1:0]  f_mx, f_my;

   assign f_axis = req_data[F_AXIS +: 2];
   assign f_seg  = req_data[F_SEG  +: 3];
   assign f_cidx = req_data[F_CIDX +: 3];
   assign f_cval = req_data[F_CVAL +: COEF_W];
   assign f_bidx = req_data[F_BIDX +: 4];
   assign f_time = req_data[F_TIME +: TIME_W];
   assign f_mx   = req_data[F_MX   +: POS_W];
   assign f_my   = req_data[F_MY   +: POS_W];

   // tables
   logic              c_we, b_we;
   logic [CAW-1:0]    c_waddr, c_raddr;
   logic [COEF_W-1:0] c_rdata;
   logic [TIME_W-1:0] b_rdata;

   assign c_we = req_accept && req_func == FUNC_COEF && 32'(f_axis) < AXES
                 && 32'(f_seg) < MAX_SEGMENTS && 32'(f_cidx) < POLY_TERMS;
   assign b_we = req_accept && req_func == FUNC_BOUND && 32'(f_bidx) <= MAX_SEGMENTS;

   pptraj_ram #(.WIDTH(COEF_W), .DEPTH(CDEPTH)) u_coef (
      .clock   (clock),
      .wr_en   (c_we),
      .wr_addr (c_waddr),
      .wr_data (f_cval),
      .rd_en   (cmd.c_rd),
      .rd_addr (c_raddr),
      .rd_data (c_rdata)
   );

   pptraj_ram #(.WIDTH(TIME_W), .DEPTH(BDEPTH)) u_bound (
      .clock   (clock),
      .wr_en   (b_we),
      .wr_addr (BAW'(f_bidx)),
      .wr_data (f_time),
      .rd_en   (cmd.b_rd),
      .rd_addr (cmd.b_addr[BAW-1:0]),
      .rd_data (b_rdata)
   );

   // registers
   logic [3:0]              segs_ff, segs_in;
   logic                    zhold_ff, zhold_in;
   logic [POS_W-1:0]        height_ff, height_in;
   logic                    started_ff, started_in;
   logic [POS_W-1:0]        sx_ff, sx_in, sy_ff, sy_in;
   logic [TIME_W-1:0]       st_ff, st_in;
   logic signed [E_W-1:0]   e_ff, e_in;
   bop_type                 bop_ff, bop_in;
   logic [BAW-1:0]          bidx_ff, bidx_in;
   logic [TIME_W-1:0]       bn_ff, bn_in, bn1_ff, bn1_in, b0_ff, b0_in, prev_ff, prev_in;
   logic                    found_ff, found_in;
   logic [SW-1:0]           sscan_ff, sscan_in, seg_ff, seg_in;
   logic signed [E_W-1:0]   dscan_ff, dscan_in, dt_ff, dt_in;
   logic [COEF_W-1:0]       term_ff, term_in, acc_ff, acc_in, mres_ff, mres_in;
   logic [MAG_W-1:0]        mua_ff, mua_in, mub_ff, mub_in;
   logic                    mneg_ff, mneg_in;
   logic [PROD_W-1:0]       prod_ff, prod_in;
   logic [POS_W-1:0]        res_ff [NUM_POLY];
   logic [POS_W-1:0]        res_in [NUM_POLY];
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]   rsp_data_ff, rsp_data_in;

   logic [BAW-1:0]          n_eff;
   logic signed [E_W-1:0]   b_ext, prev_ext, bn_ext, bn1_ext, b0_ext;
   logic [K_MAX_W-1:0]      m_val;
   logic signed [VM_W-1:0]  vm;
   logic [COEF_W-1:0]       vterm, cterm;
   logic [E_W-1:0]          dt_mag;
   logic [MAG_W+CHUNK_W-1:0] pp;
   logic [PROD_W-1:0]       pn;
   logic [POS_W-1:0]        acc_hi, store_val;

   assign c_waddr = CAW'((32'(f_axis) * MAX_SEGMENTS + 32'(f_seg)) * POLY_TERMS
                         + 32'(f_cidx));
   assign c_raddr = CAW'((32'(cmd.axis) * MAX_SEGMENTS + 32'(seg_ff)) * POLY_TERMS
                         + 32'(cmd.k));

   always_comb begin
      if (segs_ff == '0) begin
         n_eff = BAW'(1);
      end else if (32'(segs_ff) > MAX_SEGMENTS) begin
         n_eff = BAW'(MAX_SEGMENTS);
      end else begin
         n_eff = BAW'(segs_ff);
      end
   end

   assign status.n_eff    = BADDR_MAX_W'(n_eff);
   assign status.started  = started_ff;
   assign status.rsp_free = !rsp_valid_ff || rsp_ready;

   assign b_ext    = {{(E_W-TIME_W){1'b0}}, b_rdata};
   assign prev_ext = {{(E_W-TIME_W){1'b0}}, prev_ff};
   assign bn_ext   = {{(E_W-TIME_W){1'b0}}, bn_ff};
   assign bn1_ext  = {{(E_W-TIME_W){1'b0}}, bn1_ff};
   assign b0_ext   = {{(E_W-TIME_W){1'b0}}, b0_ff};

   // velocity term: coefficient times its power, saturated
   assign m_val = K_MAX_W'(POLY_TERMS - 1) - cmd.k;
   assign vm    = $signed({{(K_MAX_W+1){c_rdata[COEF_W-1]}}, c_rdata})
                  * $signed({{(COEF_W+1){1'b0}}, m_val});
   assign vterm = (vm[VM_W-1:COEF_W-1] == {(K_MAX_W+2){vm[COEF_W-1]}}) ? vm[COEF_W-1:0]
                  : (c_rdata[COEF_W-1] ? S64_MIN : S64_MAX);
   assign cterm = cmd.is_vel ? vterm : c_rdata;

   assign dt_mag = dt_ff[E_W-1] ? (~dt_ff + E_W'(1)) : dt_ff;
   assign pp     = mua_ff * mub_ff[MAG_W-1 -: CHUNK_W];
   assign pn     = mneg_ff ? (~prod_ff + PROD_W'(1)) : prod_ff;
   assign acc_hi = acc_ff[COEF_W-1 -: POS_W];

   always_comb begin
      unique case (cmd.p)
         3'd0:    store_val = pos_sat(acc_hi, sx_ff);
         3'd1:    store_val = pos_sat(acc_hi, sy_ff);
         3'd2:    store_val = zhold_ff ? height_ff : acc_hi;
         default: store_val = acc_hi;
      endcase
   end

   always_comb begin
      segs_in      = segs_ff;
      zhold_in     = zhold_ff;
      height_in    = height_ff;
      started_in   = started_ff;
      sx_in        = sx_ff;
      sy_in        = sy_ff;
      st_in        = st_ff;
      e_in         = e_ff;
      bop_in       = cmd.bop;
      bidx_in      = cmd.b_addr[BAW-1:0];
      bn_in        = bn_ff;
      bn1_in       = bn1_ff;
      b0_in        = b0_ff;
      prev_in      = prev_ff;
      found_in     = found_ff;
      sscan_in     = sscan_ff;
      dscan_in     = dscan_ff;
      seg_in       = seg_ff;
      dt_in        = dt_ff;
      term_in      = term_ff;
      acc_in       = acc_ff;
      mres_in      = mres_ff;
      mua_in       = mua_ff;
      mub_in       = mub_ff;
      mneg_in      = mneg_ff;
      prod_in      = prod_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;

      if (csr_we) begin
         unique case (csr_index)
            CSR_SEGS:   segs_in   = csr_wdata[3:0];
            CSR_ZHOLD:  zhold_in  = csr_wdata[0];
            CSR_HEIGHT: height_in = csr_wdata;
            default: ;
         endcase
      end

      if (cmd.take_start) begin
         started_in = 1'b1;
         sx_in      = f_mx;
         sy_in      = f_my;
         st_in      = f_time;
      end
      if (cmd.take_odo) begin
         e_in = $signed({{(E_W-TIME_W){1'b0}}, f_time})
                - $signed({{(E_W-TIME_W){1'b0}}, st_ff});
      end

      // boundary data is handled in the cycle after its read
      unique case (bop_ff)
         B_LAST:  bn_in  = b_rdata;
         B_PREV:  bn1_in = b_rdata;
         B_FIRST: begin
            b0_in    = b_rdata;
            prev_in  = b_rdata;
            found_in = 1'b0;
         end
         B_SCAN: begin
            if (!found_ff && e_ff >= prev_ext && e_ff <= b_ext) begin
               found_in = 1'b1;
               sscan_in = SW'(bidx_ff - BAW'(1));
               dscan_in = e_ff - prev_ext;
            end
            prev_in = b_rdata;
         end
         default: ;
      endcase

      if (cmd.sel_seg) begin
         if (e_ff >= bn_ext) begin
            seg_in = SW'(n_eff - BAW'(1));
            dt_in  = bn_ext - bn1_ext;
         end else if (found_ff) begin
            seg_in = sscan_ff;
            dt_in  = dscan_ff;
         end else begin
            seg_in = '0;
            dt_in  = e_ff - b0_ext;
         end
      end

      if (cmd.c_lat) begin
         term_in = cterm;
         if (cmd.first) begin
            acc_in = cterm;
         end else begin
            mua_in  = acc_ff[COEF_W-1] ? (~acc_ff + COEF_W'(1)) : acc_ff;
            mub_in  = MAG_W'(dt_mag);
            mneg_in = acc_ff[COEF_W-1] ^ dt_ff[E_W-1];
            prod_in = '0;
         end
      end

      if (cmd.mul_step) begin
         prod_in = {prod_ff[PROD_W-CHUNK_W-1:0], {CHUNK_W{1'b0}}} + PROD_W'(pp);
         mub_in  = {mub_ff[MAG_W-CHUNK_W-1:0], {CHUNK_W{1'b0}}};
      end

      if (cmd.mul_fin) begin
         if (pn[PROD_W-1:HI_B] == {(PROD_W-HI_B){pn[HI_B]}}) begin
            mres_in = pn[HI_B:FRAC_SH];
         end else begin
            mres_in = pn[PROD_W-1] ? S64_MIN : S64_MAX;
         end
      end

      if (cmd.add) begin
         acc_in = sat_add(mres_ff, term_ff);
      end

      if (cmd.store) begin
         res_in[cmd.p] = store_val;
      end

      if (cmd.publish) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {{(RSP_DATA_W-NUM_POLY*POS_W-3){1'b0}}, 3'(seg_ff),
                         res_ff[5], res_ff[4], res_ff[3], res_ff[2], res_ff[1], res_ff[0]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         segs_ff      <= 4'd3;
         zhold_ff     <= 1'b1;
         height_ff    <= 32'h0001_0000;
         started_ff   <= 1'b0;
         sx_ff        <= '0;
         sy_ff        <= '0;
         st_ff        <= '0;
         bop_ff       <= B_NONE;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         segs_ff      <= segs_in;
         zhold_ff     <= zhold_in;
         height_ff    <= height_in;
         started_ff   <= started_in;
         sx_ff        <= sx_in;
         sy_ff        <= sy_in;
         st_ff        <= st_in;
         bop_ff       <= bop_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      e_ff        <= e_in;
      bidx_ff     <= bidx_in;
      bn_ff       <= bn_in;
      bn1_ff      <= bn1_in;
      b0_ff       <= b0_in;
      prev_ff     <= prev_in;
      sscan_ff    <= sscan_in;
      dscan_ff    <= dscan_in;
      seg_ff      <= seg_in;
      dt_ff       <= dt_in;
      term_ff     <= term_in;
      acc_ff      <= acc_in;
      mres_ff     <= mres_in;
      mua_ff      <= mua_in;
      mub_ff      <= mub_in;
      mneg_ff     <= mneg_in;
      prod_ff     <= prod_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
endmodule
`default_nettype wire

[src/piecewise_poly_trajectory_eval.sv]
// Top level of the piecewise polynomial trajectory evaluator.
// Usage:
//  - req beats carry a kind in req_tuser: coefficient load, boundary load or
//    odometry sample. Loads are taken one per cycle while the sequencer is idle and give no result.
//  - The first odometry beat after reset latches start x/y and start time and
//    gives no result. Every later one yields exactly one rsp beat.
//  - An odometry beat occupies the block up to rsp_tvalid: a boundary scan
//    through the boundary RAM port, then six Horner evaluations on one
//    64x16 multiplier, each step after the first being four multiplier
//    passes plus read, scale and add.
//  - req_tready is high whenever the sequencer is idle; the result sits in an
//    output register, so the next beat is taken while rsp waits.
//  - If rsp_tready stays low, a finished result waits inside until the output
//    register frees up, and req_tready stays low meanwhile.
//  - Reset (synchronous) clears the start capture, the output and the config
//    registers (3 segments, z hold on, hold height 1.0 m); the tables keep
//    their content and must be loaded before use.
//  - csr writes are taken at any edge with csr_we; write them only while idle.
`default_nettype none
module piecewise_poly_trajectory_eval #(
   parameter int MAX_SEGMENTS = pptraj_pkg::MAX_SEGMENTS_DEF,
   parameter int POLY_TERMS   = pptraj_pkg::POLY_TERMS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // axis, segment, coeff_index, coeff_value, boundary_index, time_value,
   // meas_x, meas_y, meas_z
   input  logic [pptraj_pkg::REQ_DATA_W-1:0] req_tdata,
   // func
   input  logic [pptraj_pkg::REQ_USER_W-1:0] req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // cmd_pos_x, cmd_pos_y, cmd_pos_z, cmd_vel_x, cmd_vel_y, cmd_vel_z, segment_used
   output logic [pptraj_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                              csr_we,
   input  logic [pptraj_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [pptraj_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import pptraj_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;
   logic          req_accept;
   func_type      req_func;

   assign req_accept = req_tvalid && req_tready;
   assign req_func   = func_type'(req_tuser);

   pptraj_ctrl #(.MAX_SEGMENTS(MAX_SEGMENTS), .POLY_TERMS(POLY_TERMS)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_accept),
      .req_func   (req_func),
      .status     (status),
      .req_ready  (req_tready),
      .cmd        (cmd)
   );

   pptraj_dp #(.MAX_SEGMENTS(MAX_SEGMENTS), .POLY_TERMS(POLY_TERMS)) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_accept),
      .req_func   (req_func),
      .req_data   (req_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .status     (status),
      .rsp_ready  (rsp_tready),
      .rsp_valid  (rsp_tvalid),
      .rsp_data   (rsp_tdata)
   );
endmodule
`default_nettype wire

[src/pptraj_chk.sv]
// Port-level checker for the trajectory evaluator, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module pptraj_chk (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic [pptraj_pkg::REQ_USER_W-1:0] req_tuser,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [pptraj_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import pptraj_pkg::*;

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "rsp beat changed while stalled")
   `ASSERT_NEXT(a_load_no_stall, clock, reset, req_tvalid && req_tready && req_tuser != FUNC_ODOM, req_tready, "load beat stalled the input")
   `ASSERT_NEXT(a_idle_ready, clock, reset, req_tready && !(req_tvalid && req_tuser == FUNC_ODOM), req_tready, "input stalled without an odometry beat")
   `ASSERT_SAME(a_rsp_from_busy, clock, reset, $rose(rsp_tvalid), $past(!req_tready), "result appeared while idle")
endmodule

bind piecewise_poly_trajectory_eval pptraj_chk u_chk (.*);
`default_nettype wire
